/* rtl/c_operator_token_lexer_assert.svh */
// Assertion helpers shared by the lexer RTL.
// Each macro expands to one labeled concurrent assertion, disabled in reset.
`ifndef C_OPERATOR_TOKEN_LEXER_ASSERT_SVH
`define C_OPERATOR_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication.
`define COTL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer assertion failed");

// Next-cycle implication.
`define COTL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer assertion failed");

`endif

/* rtl/cotl_pkg.sv */
// ----------------------------------------------------------------------------
// cotl_pkg
// Token codes, character codes and pending-operator states of the C operator
// lexer, plus the close-code lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cotl_pkg;

  // Bundles in flight between the front and back ends.
  localparam int Q_DEPTH = 2;
  // Tokens one input word can cause.
  localparam int MAX_TOK = 3;

  typedef enum logic [4:0] {
    PEND_NONE, PEND_PLUS, PEND_MINUS, PEND_STAR, PEND_SLASH, PEND_PCT, PEND_EQ,
    PEND_BANG, PEND_LT, PEND_LTLT, PEND_GT, PEND_GTGT, PEND_DOT, PEND_DOTDOT,
    PEND_AMP, PEND_BAR, PEND_CARET
  } pend_e;

  localparam logic [5:0] TK_TILDE   = 6'd0;
  localparam logic [5:0] TK_LPAREN  = 6'd1;
  localparam logic [5:0] TK_RPAREN  = 6'd2;
  localparam logic [5:0] TK_LBRACK  = 6'd3;
  localparam logic [5:0] TK_RBRACK  = 6'd4;
  localparam logic [5:0] TK_LBRACE  = 6'd5;
  localparam logic [5:0] TK_RBRACE  = 6'd6;
  localparam logic [5:0] TK_SEMI    = 6'd7;
  localparam logic [5:0] TK_COMMA   = 6'd8;
  localparam logic [5:0] TK_COLON   = 6'd9;
  localparam logic [5:0] TK_INC     = 6'd10;
  localparam logic [5:0] TK_ADDEQ   = 6'd11;
  localparam logic [5:0] TK_PLUS    = 6'd12;
  localparam logic [5:0] TK_DEC     = 6'd13;
  localparam logic [5:0] TK_SUBEQ   = 6'd14;
  localparam logic [5:0] TK_ARROW   = 6'd15;
  localparam logic [5:0] TK_MINUS   = 6'd16;
  localparam logic [5:0] TK_MULEQ   = 6'd17;
  localparam logic [5:0] TK_STAR    = 6'd18;
  localparam logic [5:0] TK_DIVEQ   = 6'd19;
  localparam logic [5:0] TK_SLASH   = 6'd20;
  localparam logic [5:0] TK_MODEQ   = 6'd21;
  localparam logic [5:0] TK_PCT     = 6'd22;
  localparam logic [5:0] TK_EQEQ    = 6'd23;
  localparam logic [5:0] TK_ASSIGN  = 6'd24;
  localparam logic [5:0] TK_NE      = 6'd25;
  localparam logic [5:0] TK_BANG    = 6'd26;
  localparam logic [5:0] TK_LE      = 6'd27;
  localparam logic [5:0] TK_SHLEQ   = 6'd28;
  localparam logic [5:0] TK_SHL     = 6'd29;
  localparam logic [5:0] TK_LT      = 6'd30;
  localparam logic [5:0] TK_GE      = 6'd31;
  localparam logic [5:0] TK_SHREQ   = 6'd32;
  localparam logic [5:0] TK_SHR     = 6'd33;
  localparam logic [5:0] TK_GT      = 6'd34;
  localparam logic [5:0] TK_ELLIPS  = 6'd35;
  localparam logic [5:0] TK_DOT     = 6'd36;
  localparam logic [5:0] TK_ANDEQ   = 6'd37;
  localparam logic [5:0] TK_LAND    = 6'd38;
  localparam logic [5:0] TK_AMP     = 6'd39;
  localparam logic [5:0] TK_OREQ    = 6'd40;
  localparam logic [5:0] TK_LOR     = 6'd41;
  localparam logic [5:0] TK_BAR     = 6'd42;
  localparam logic [5:0] TK_XOREQ   = 6'd43;
  localparam logic [5:0] TK_CARET   = 6'd44;

  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_CARET  = 8'h5E;

  // Token for a pending operator that closes without extension.
  function automatic logic [5:0] close_code(input pend_e p);
    logic [5:0] code;
    case (p)
      PEND_PLUS:   code = TK_PLUS;
      PEND_MINUS:  code = TK_MINUS;
      PEND_STAR:   code = TK_STAR;
      PEND_SLASH:  code = TK_SLASH;
      PEND_PCT:    code = TK_PCT;
      PEND_EQ:     code = TK_ASSIGN;
      PEND_BANG:   code = TK_BANG;
      PEND_LT:     code = TK_LT;
      PEND_LTLT:   code = TK_SHL;
      PEND_GT:     code = TK_GT;
      PEND_GTGT:   code = TK_SHR;
      PEND_DOT:    code = TK_DOT;
      PEND_DOTDOT: code = TK_DOT;
      PEND_AMP:    code = TK_AMP;
      PEND_BAR:    code = TK_BAR;
      PEND_CARET:  code = TK_CARET;
      default:     code = TK_TILDE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/cotl_front.sv */
// ----------------------------------------------------------------------------
// cotl_front
// Accepts source words, tracks the pending operator and packs every token a
// word causes into one bundle for the token queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cotl_front #(
  parameter int LINE_BITS = 20,
  parameter int TOK_W     = 6 + 20 + 32,
  parameter int BUNDLE_W  = 2 + 3 * (6 + 20 + 32)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           char_i,
  input  wire logic [LINE_BITS-1:0] line_i,
  input  wire logic [31:0]          off_i,
  input  wire logic                 eos_i,
  output logic                      push_o,
  input  wire logic                 q_ready_i,
  output logic [BUNDLE_W-1:0]       bundle_o
);

  cotl_pkg::pend_e          pend_q, pend_d;
  logic [LINE_BITS-1:0]     pline_q, pline_d;

  logic [cotl_pkg::MAX_TOK-1:0][TOK_W-1:0] toks;
  logic [1:0]               n;
  logic                     fire;

  cotl_pkg::pend_e          ext_next;
  logic                     ext_next_vld;
  logic [5:0]               ext_code;
  logic                     ext_code_vld;
  logic                     do_flush, do_fresh;

  logic [5:0]               fr_code;
  logic                     fr_single, fr_has_off;
  cotl_pkg::pend_e          fr_start;

  assign in_ready_o = q_ready_i;
  assign fire       = in_valid_i && q_ready_i;

  // How the pending operator reacts to the byte.
  always_comb begin
    ext_next     = cotl_pkg::PEND_NONE;
    ext_next_vld = 1'b0;
    ext_code     = cotl_pkg::TK_TILDE;
    ext_code_vld = 1'b0;
    case (pend_q)
      cotl_pkg::PEND_PLUS: begin
        if (char_i == cotl_pkg::CH_PLUS) begin
          ext_code = cotl_pkg::TK_INC;   ext_code_vld = 1'b1;
        end else if (char_i == cotl_pkg::CH_EQ) begin
          ext_code = cotl_pkg::TK_ADDEQ; ext_code_vld = 1'b1;
        end
      end
      cotl_pkg::PEND_MINUS: begin
        if (char_i == cotl_pkg::CH_MINUS) begin
          ext_code = cotl_pkg::TK_DEC;   ext_code_vld = 1'b1;
        end else if (char_i == cotl_pkg::CH_EQ) begin
          ext_code = cotl_pkg::TK_SUBEQ; ext_code_vld = 1'b1;
        end else if (char_i == cotl_pkg::CH_GT) begin
          ext_code = cotl_pkg::TK_ARROW; ext_code_vld = 1'b1;
        end
      end
      cotl_pkg::PEND_STAR: begin
        ext_code = cotl_pkg::TK_MULEQ; ext_code_vld = (char_i == cotl_pkg::CH_EQ);
      end
      cotl_pkg::PEND_SLASH: begin
        ext_code = cotl_pkg::TK_DIVEQ; ext_code_vld = (char_i == cotl_pkg::CH_EQ);
      end
      cotl_pkg::PEND_PCT: begin
        ext_code = cotl_pkg::TK_MODEQ; ext_code_vld = (char_i == cotl_pkg::CH_EQ);
      end
      cotl_pkg::PEND_EQ: begin
        ext_code = cotl_pkg::TK_EQEQ; ext_code_vld = (char_i == cotl_pkg::CH_EQ);
      end
      cotl_pkg::PEND_BANG: begin
        ext_code = cotl_pkg::TK_NE; ext_code_vld = (char_i == cotl_pkg::CH_EQ);
      end
      cotl_pkg::PEND_LT: begin
        if (char_i == cotl_pkg::CH_EQ) begin
          ext_code = cotl_pkg::TK_LE; ext_code_vld = 1'b1;
        end else if (char_i == cotl_pkg::CH_LT) begin
          ext_next = cotl_pkg::PEND_LTLT; ext_next_vld = 1'b1;
        end
      end
      cotl_pkg::PEND_LTLT: begin
        ext_code = cotl_pkg::TK_SHLEQ; ext_code_vld = (char_i == cotl_pkg::CH_EQ);
      end
      cotl_pkg::PEND_GT: begin
        if (char_i == cotl_pkg::CH_EQ) begin
          ext_code = cotl_pkg::TK_GE; ext_code_vld = 1'b1;
        end else if (char_i == cotl_pkg::CH_GT) begin
          ext_next = cotl_pkg::PEND_GTGT; ext_next_vld = 1'b1;
        end
      end
      cotl_pkg::PEND_GTGT: begin
        ext_code = cotl_pkg::TK_SHREQ; ext_code_vld = (char_i == cotl_pkg::CH_EQ);
      end
      cotl_pkg::PEND_DOT: begin
        ext_next = cotl_pkg::PEND_DOTDOT; ext_next_vld = (char_i == cotl_pkg::CH_DOT);
      end
      cotl_pkg::PEND_DOTDOT: begin
        ext_code = cotl_pkg::TK_ELLIPS; ext_code_vld = (char_i == cotl_pkg::CH_DOT);
      end
      cotl_pkg::PEND_AMP: begin
        if (char_i == cotl_pkg::CH_EQ) begin
          ext_code = cotl_pkg::TK_ANDEQ; ext_code_vld = 1'b1;
        end else if (char_i == cotl_pkg::CH_AMP) begin
          ext_code = cotl_pkg::TK_LAND;  ext_code_vld = 1'b1;
        end
      end
      cotl_pkg::PEND_BAR: begin
        if (char_i == cotl_pkg::CH_EQ) begin
          ext_code = cotl_pkg::TK_OREQ; ext_code_vld = 1'b1;
        end else if (char_i == cotl_pkg::CH_BAR) begin
          ext_code = cotl_pkg::TK_LOR;  ext_code_vld = 1'b1;
        end
      end
      cotl_pkg::PEND_CARET: begin
        ext_code = cotl_pkg::TK_XOREQ; ext_code_vld = (char_i == cotl_pkg::CH_EQ);
      end
      default: begin
      end
    endcase
  end

  // How the byte is handled when nothing is pending.
  always_comb begin
    fr_code    = cotl_pkg::TK_TILDE;
    fr_single  = 1'b1;
    fr_has_off = 1'b0;
    fr_start   = cotl_pkg::PEND_NONE;
    case (char_i)
      cotl_pkg::CH_TILDE:  fr_code = cotl_pkg::TK_TILDE;
      cotl_pkg::CH_LPAREN: fr_code = cotl_pkg::TK_LPAREN;
      cotl_pkg::CH_RPAREN: fr_code = cotl_pkg::TK_RPAREN;
      cotl_pkg::CH_LBRACK: fr_code = cotl_pkg::TK_LBRACK;
      cotl_pkg::CH_RBRACK: fr_code = cotl_pkg::TK_RBRACK;
      cotl_pkg::CH_LBRACE: fr_code = cotl_pkg::TK_LBRACE;
      cotl_pkg::CH_RBRACE: begin
        fr_code = cotl_pkg::TK_RBRACE; fr_has_off = 1'b1;
      end
      cotl_pkg::CH_SEMI: begin
        fr_code = cotl_pkg::TK_SEMI; fr_has_off = 1'b1;
      end
      cotl_pkg::CH_COMMA:  fr_code = cotl_pkg::TK_COMMA;
      cotl_pkg::CH_COLON:  fr_code = cotl_pkg::TK_COLON;
      default: begin
        fr_single = 1'b0;
        case (char_i)
          cotl_pkg::CH_PLUS:  fr_start = cotl_pkg::PEND_PLUS;
          cotl_pkg::CH_MINUS: fr_start = cotl_pkg::PEND_MINUS;
          cotl_pkg::CH_STAR:  fr_start = cotl_pkg::PEND_STAR;
          cotl_pkg::CH_SLASH: fr_start = cotl_pkg::PEND_SLASH;
          cotl_pkg::CH_PCT:   fr_start = cotl_pkg::PEND_PCT;
          cotl_pkg::CH_EQ:    fr_start = cotl_pkg::PEND_EQ;
          cotl_pkg::CH_BANG:  fr_start = cotl_pkg::PEND_BANG;
          cotl_pkg::CH_LT:    fr_start = cotl_pkg::PEND_LT;
          cotl_pkg::CH_GT:    fr_start = cotl_pkg::PEND_GT;
          cotl_pkg::CH_DOT:   fr_start = cotl_pkg::PEND_DOT;
          cotl_pkg::CH_AMP:   fr_start = cotl_pkg::PEND_AMP;
          cotl_pkg::CH_BAR:   fr_start = cotl_pkg::PEND_BAR;
          cotl_pkg::CH_CARET: fr_start = cotl_pkg::PEND_CARET;
          default:            fr_start = cotl_pkg::PEND_NONE;
        endcase
      end
    endcase
  end

  // Build the token bundle and the next pending state.
  always_comb begin
    pend_d   = pend_q;
    pline_d  = pline_q;
    toks     = '0;
    n        = 2'd0;
    do_flush = 1'b0;
    do_fresh = 1'b0;

    if (eos_i) begin
      do_flush = 1'b1;
    end else if (pend_q == cotl_pkg::PEND_NONE) begin
      do_fresh = 1'b1;
    end else if (ext_next_vld) begin
      pend_d = ext_next;
    end else if (ext_code_vld) begin
      toks[n] = {32'd0, pline_q, ext_code};
      n       = n + 2'd1;
      pend_d  = cotl_pkg::PEND_NONE;
    end else begin
      do_flush = 1'b1;
      do_fresh = 1'b1;
    end

    if (do_flush) begin
      // two dots without a third close as two separate dots
      if (pend_q == cotl_pkg::PEND_DOTDOT) begin
        toks[n] = {32'd0, pline_q, cotl_pkg::TK_DOT};
        n       = n + 2'd1;
      end
      if (pend_q != cotl_pkg::PEND_NONE) begin
        toks[n] = {32'd0, pline_q, cotl_pkg::close_code(pend_q)};
        n       = n + 2'd1;
      end
      pend_d = cotl_pkg::PEND_NONE;
    end

    if (do_fresh) begin
      if (fr_single) begin
        toks[n] = {(fr_has_off ? off_i : 32'd0), line_i, fr_code};
        n       = n + 2'd1;
      end else if (fr_start != cotl_pkg::PEND_NONE) begin
        pend_d  = fr_start;
        pline_d = line_i;
      end
    end
  end

  assign push_o   = fire && (n != 2'd0);
  assign bundle_o = {toks, n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= cotl_pkg::PEND_NONE;
      pline_q <= '0;
    end else if (fire) begin
      pend_q  <= pend_d;
      pline_q <= pline_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/cotl_queue.sv */
// ----------------------------------------------------------------------------
// cotl_queue
// Short bundle FIFO that decouples the classifier from the token emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "c_operator_token_lexer_assert.svh"

module cotl_queue #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] push_data_i,
  output logic              ready_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic [W-1:0]      pop_data_o
);

  localparam int PTR_W = $clog2(cotl_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(cotl_pkg::Q_DEPTH + 1);

  logic [W-1:0]     mem_q [cotl_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o    = (count_q != CNT_W'(cotl_pkg::Q_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(cotl_pkg::Q_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(cotl_pkg::Q_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `COTL_ASSERT_IMP(a_q_no_overflow, clk_i, rst_ni, push_i, ready_o)
  `COTL_ASSERT_IMP(a_q_count_range, clk_i, rst_ni, 1'b1,
                   count_q <= CNT_W'(cotl_pkg::Q_DEPTH))
  `COTL_ASSERT_NXT(a_q_push_seen, clk_i, rst_ni, do_push, valid_o)

endmodule

`default_nettype wire

/* rtl/cotl_back.sv */
// ----------------------------------------------------------------------------
// cotl_back
// Takes bundles from the queue and sends their tokens one word at a time,
// marking the last token of each input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "c_operator_token_lexer_assert.svh"

module cotl_back #(
  parameter int TOK_W    = 6 + 20 + 32,
  parameter int BUNDLE_W = 2 + 3 * (6 + 20 + 32)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire logic [BUNDLE_W-1:0] q_data_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [TOK_W-1:0]         out_tok_o,
  output logic                     out_last_o
);

  logic [BUNDLE_W-1:0] cur_q;
  logic                valid_q;
  logic [1:0]          idx_q;
  logic [1:0]          cnt;
  logic                fire, done, load;

  assign cnt         = cur_q[1:0];
  assign out_valid_o = valid_q;
  assign out_last_o  = (idx_q == 2'(cnt - 2'd1));
  assign fire        = valid_q && out_ready_i;
  assign done        = fire && out_last_o;
  assign load        = !valid_q || done;
  assign q_pop_o     = load && q_valid_i;

  always_comb begin
    case (idx_q)
      2'd1:    out_tok_o = cur_q[2 + TOK_W +: TOK_W];
      2'd2:    out_tok_o = cur_q[2 + 2 * TOK_W +: TOK_W];
      default: out_tok_o = cur_q[2 +: TOK_W];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= q_valid_i;
      idx_q   <= 2'd0;
    end else if (fire) begin
      idx_q   <= idx_q + 2'd1;
    end
  end

  // advance to the next bundle as the last token leaves
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  `COTL_ASSERT_IMP(a_b_cnt_nonzero, clk_i, rst_ni, valid_q, cnt != 2'd0)
  `COTL_ASSERT_IMP(a_b_idx_in_range, clk_i, rst_ni, valid_q, idx_q < cnt)
  `COTL_ASSERT_NXT(a_b_stall_holds, clk_i, rst_ni, valid_q && !out_ready_i,
                   valid_q && $stable(idx_q))

endmodule

`default_nettype wire

/* rtl/c_operator_token_lexer.sv */
// ----------------------------------------------------------------------------
// c_operator_token_lexer
// C operator and punctuator lexer: longest match over source bytes, one byte
// per word in, one token per word out.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                          side band
//  s_axis    in   char_code[8] line_number[LB] byte_offset[32]  tuser: end_of_stream
//  m_axis    out  token_code[6] token_line[LB] token_offset[32] tlast: last_of_run
//
//  Input accepts one byte per cycle while the bundle queue has room.
//  Each byte yields 0..3 tokens; the output side sends one token per cycle
//  while tready is high, so a byte with k tokens holds the emitter for all k sends.
//  The two-entry queue lets the input keep flowing while output stalls.
//  Reset clears the pending operator and the queue; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c_operator_token_lexer #(
  parameter int LINE_BITS = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // char_code, line_number, byte_offset, zero pad
  input  wire logic [((40 + LINE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // end_of_stream
  input  wire logic                s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // token_code, token_line, token_offset, zero pad
  output logic [((38 + LINE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // last_of_run
  output logic                     m_axis_tlast_o
);

  localparam int OUT_W    = ((38 + LINE_BITS + 7) / 8) * 8;
  localparam int TOK_W    = 6 + LINE_BITS + 32;
  localparam int BUNDLE_W = 2 + cotl_pkg::MAX_TOK * TOK_W;

  logic                push, q_ready, q_valid, q_pop;
  logic [BUNDLE_W-1:0] push_data, pop_data;
  logic [TOK_W-1:0]    tok;

  cotl_front #(
    .LINE_BITS (LINE_BITS),
    .TOK_W     (TOK_W),
    .BUNDLE_W  (BUNDLE_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .char_i     (s_axis_tdata_i[7:0]),
    .line_i     (s_axis_tdata_i[8 +: LINE_BITS]),
    .off_i      (s_axis_tdata_i[8 + LINE_BITS +: 32]),
    .eos_i      (s_axis_tuser_i),
    .push_o     (push),
    .q_ready_i  (q_ready),
    .bundle_o   (push_data)
  );

  cotl_queue #(
    .W (BUNDLE_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  cotl_back #(
    .TOK_W    (TOK_W),
    .BUNDLE_W (BUNDLE_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tok_o   (tok),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OUT_W'(tok);

endmodule

`default_nettype wire
